[src/psgtn_pkg.sv]
// Package for the tone/noise sound generator: channel state entry type,
// request, channel and noise rate codes, attenuation level table and per-channel reset values.
// No dependencies.
package psgtn_pkg;

    localparam int NUM_CH = 4;

    typedef logic [1:0] t_ch;

    // Request codes carried on req_type.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Channel numbers and noise rate codes.
    localparam t_ch        CH_TONE2    = 2'd2;
    localparam t_ch        CH_NOISE    = 2'd3;
    localparam logic [1:0] RATE_DIV16  = 2'd0;
    localparam logic [1:0] RATE_DIV32  = 2'd1;
    localparam logic [1:0] RATE_DIV64  = 2'd2;
    localparam logic [1:0] RATE_TONE2  = 2'd3;

    localparam logic [10:0] PERIOD_DIV16 = 11'h010;
    localparam logic [10:0] PERIOD_DIV32 = 11'h020;
    localparam logic [10:0] PERIOD_DIV64 = 11'h040;
    localparam logic [10:0] PERIOD_ZERO  = 11'h400;
    localparam logic [14:0] LFSR_SEED    = 15'h4000;
    localparam logic [3:0]  ATTEN_RESET  = 4'd4;
    localparam logic [12:0] MIX_FULL     = 13'd4096;

    // One entry of the channel state memory.
    typedef struct packed {
        logic [3:0]  atten;
        logic [9:0]  tone;
        logic [10:0] reload;
        logic [10:0] count;
        logic        state;
    } t_chan_entry;

    // Level for an attenuation step, full scale 1024.
    function automatic logic [10:0] level_of(input logic [3:0] idx);
        logic [10:0] lvl;
        case (idx)
            4'd0:    lvl = 11'd1024;
            4'd1:    lvl = 11'd813;
            4'd2:    lvl = 11'd646;
            4'd3:    lvl = 11'd513;
            4'd4:    lvl = 11'd408;
            4'd5:    lvl = 11'd324;
            4'd6:    lvl = 11'd257;
            4'd7:    lvl = 11'd204;
            4'd8:    lvl = 11'd162;
            4'd9:    lvl = 11'd129;
            4'd10:   lvl = 11'd102;
            4'd11:   lvl = 11'd81;
            4'd12:   lvl = 11'd65;
            4'd13:   lvl = 11'd51;
            4'd14:   lvl = 11'd41;
            default: lvl = 11'd0;
        endcase
        return lvl;
    endfunction

    // State of a channel entry after reset.
    function automatic t_chan_entry reset_entry(input t_ch ch);
        t_chan_entry e;
        e.atten = ATTEN_RESET;
        e.tone  = 10'd0;
        e.state = 1'b0;
        case (ch)
            2'd0:    e.reload = 11'd1;
            2'd1:    e.reload = 11'd1024;
            2'd2:    e.reload = 11'd1024;
            default: e.reload = PERIOD_DIV16;
        endcase
        e.count = e.reload;
        return e;
    endfunction

endpackage

[src/psg_tone_noise_generator.sv]
// Tone/noise sound generator top level: sequencer over a four-entry channel
// state memory, noise shift register and output register.
// Depends on psgtn_pkg.
//
// Three square-wave tone channels and one noise channel. Each request is
// either a byte written to the chip (req_type 0) or one tick of the
// prescaled reference clock (req_type 1); every request gives exactly one
// result: the mix level (sum of the four channel levels, 4096 = 1.0) and
// the four channel output states, as they stand after the request. A write
// never ticks. Per-channel state (attenuation, tone value, period, counter,
// output state) lives in a four-entry memory with registered read; a request
// walks the channels 0..3, one entry per cycle, reading one entry while the
// previous one is modified and written back. The next request enters
// while the last channel step of the previous one finishes, so requests
// overlap while the output is not stalled. A finished result sits in an
// output register; a stalled result holds the last channel step until the
// register frees. No clearing pass: reset marks all entries as holding
// their reset values.
module psg_tone_noise_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [0:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [12:0] o_mix_level,
    output logic [3:0]  o_channel_states
);

    // Channel state memory and its entry valid bits.
    psgtn_pkg::t_chan_entry r_mem [psgtn_pkg::NUM_CH];
    logic [3:0]             r_valid;
    psgtn_pkg::t_chan_entry r_rd_data;
    logic                   r_rd_vld;

    // Sequencer.
    logic           r_busy;
    psgtn_pkg::t_ch r_slot;

    // Request being worked on.
    logic       r_item_tick;
    logic [7:0] r_item_data;
    logic [2:0] r_item_sel;

    // Global state kept in flops.
    logic [2:0]  r_latched_select;
    logic [2:0]  r_noise_ctrl;
    logic [14:0] r_lfsr;
    logic        r_toggle;
    logic        r_noise_clk;

    // Accumulation and output.
    logic [12:0] r_acc;
    logic [2:0]  r_states;
    logic        r_out_valid;
    logic [12:0] r_mix;
    logic [3:0]  r_chst;

    logic                   can_finish;
    logic                   adv;
    logic                   accept;
    logic                   rd_en;
    psgtn_pkg::t_ch         rd_addr;
    logic [2:0]             in_sel;
    psgtn_pkg::t_chan_entry e;
    psgtn_pkg::t_chan_entry ne;
    logic [10:0]            dec;
    logic [9:0]             tone_v;
    logic                   from_tone;
    logic                   noise_clk;
    logic                   tone_clk;
    logic                   fb;
    logic [14:0]            n_lfsr;
    logic                   n_toggle;
    logic [10:0]            lvl;
    logic [12:0]            mix_sum;

    // Handshake: the last channel step may finish only when the output
    // register is free or being drained this cycle.
    assign can_finish = !r_out_valid || !i_stall;
    assign adv        = r_busy && ((r_slot != psgtn_pkg::CH_NOISE) || can_finish);
    assign o_stall    = r_busy && !((r_slot == psgtn_pkg::CH_NOISE) && can_finish);
    assign accept     = i_valid && !o_stall;

    // Select for this request: a latch byte overrides the held select.
    assign in_sel = i_data_byte[7] ? i_data_byte[6:4] : r_latched_select;

    // Read the next entry: channel 0 on a new request, else the next slot.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_slot + 2'd1;
        if (accept) begin
            rd_en   = 1'b1;
            rd_addr = 2'd0;
        end else if (adv && (r_slot != psgtn_pkg::CH_NOISE)) begin
            rd_en = 1'b1;
        end
    end

    // Modify the entry of the current slot.
    always_comb begin
        e         = r_rd_vld ? r_rd_data : psgtn_pkg::reset_entry(r_slot);
        ne        = e;
        dec       = e.count - 11'd1;
        tone_v    = e.tone;
        from_tone = (r_noise_ctrl[1:0] == psgtn_pkg::RATE_TONE2);
        noise_clk = 1'b0;
        tone_clk  = 1'b0;
        fb        = 1'b0;
        n_lfsr    = r_lfsr;
        n_toggle  = r_toggle;
        if (r_item_tick == psgtn_pkg::REQ_TICK) begin
            if (r_slot != psgtn_pkg::CH_NOISE) begin
                if (dec == 11'd0) begin
                    ne.state = ~e.state;
                    ne.count = e.reload;
                    // A rise of the tone 2 output clocks the noise in tone-driven mode.
                    tone_clk = (r_slot == psgtn_pkg::CH_TONE2) && !e.state;
                end else begin
                    ne.count = dec;
                end
            end else begin
                if (from_tone) begin
                    noise_clk = r_noise_clk;
                end else if (dec == 11'd0) begin
                    n_toggle  = ~r_toggle;
                    ne.count  = e.reload;
                    noise_clk = ~r_toggle;
                end else begin
                    ne.count = dec;
                end
                if (noise_clk) begin
                    fb       = r_noise_ctrl[2] ? (r_lfsr[0] ^ r_lfsr[1]) : r_lfsr[0];
                    n_lfsr   = {fb, r_lfsr[14:1]};
                    ne.state = r_lfsr[1];
                end
            end
        end else if (r_item_sel[2:1] == r_slot) begin
            if (r_item_sel[0]) begin
                ne.atten = r_item_data[3:0];
            end else if (r_slot != psgtn_pkg::CH_NOISE) begin
                if (r_item_data[7]) begin
                    tone_v = {e.tone[9:4], r_item_data[3:0]};
                end else begin
                    tone_v = {r_item_data[5:0], e.tone[3:0]};
                end
                ne.tone   = tone_v;
                ne.reload = (tone_v == 10'd0) ? psgtn_pkg::PERIOD_ZERO : {1'b0, tone_v};
            end else begin
                // Any noise write reapplies the rate and reseeds the shift register.
                case (r_noise_ctrl[1:0])
                    psgtn_pkg::RATE_DIV16: ne.reload = psgtn_pkg::PERIOD_DIV16;
                    psgtn_pkg::RATE_DIV32: ne.reload = psgtn_pkg::PERIOD_DIV32;
                    psgtn_pkg::RATE_DIV64: ne.reload = psgtn_pkg::PERIOD_DIV64;
                    default:               ne.reload = e.reload;
                endcase
                n_lfsr = psgtn_pkg::LFSR_SEED;
            end
        end
        lvl     = ne.state ? psgtn_pkg::level_of(ne.atten) : 11'd0;
        mix_sum = r_acc + {2'b00, lvl};
    end

    // Memory: write back the current slot, read the next one.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mem[r_slot] <= ne;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
        end
    end

    // Sequencer and global state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_slot           <= 2'd0;
            r_latched_select <= 3'd0;
            r_noise_ctrl     <= 3'd0;
            r_lfsr           <= psgtn_pkg::LFSR_SEED;
            r_toggle         <= 1'b0;
            r_noise_clk      <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (adv) begin
                if (r_slot == psgtn_pkg::CH_TONE2) begin
                    r_noise_clk <= tone_clk;
                end
                if (r_slot == psgtn_pkg::CH_NOISE) begin
                    r_lfsr   <= n_lfsr;
                    r_toggle <= n_toggle;
                end
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_slot <= 2'd0;
                if ((i_req_type == psgtn_pkg::REQ_WRITE) && i_data_byte[7]) begin
                    r_latched_select <= i_data_byte[6:4];
                    if (i_data_byte[6:4] == {psgtn_pkg::CH_NOISE, 1'b0}) begin
                        r_noise_ctrl <= i_data_byte[2:0];
                    end
                end
            end else if (adv) begin
                if (r_slot == psgtn_pkg::CH_NOISE) begin
                    r_busy <= 1'b0;
                    r_slot <= 2'd0;
                end else begin
                    r_slot <= r_slot + 2'd1;
                end
            end
            // Hold a result until taken; load one when the last step finishes.
            if (adv && (r_slot == psgtn_pkg::CH_NOISE)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and accumulation.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item_tick <= i_req_type[0];
            r_item_data <= i_data_byte;
            r_item_sel  <= in_sel;
            r_acc       <= 13'd0;
        end else if (adv && (r_slot != psgtn_pkg::CH_NOISE)) begin
            r_acc <= mix_sum;
        end
        if (adv) begin
            if (r_slot == psgtn_pkg::CH_NOISE) begin
                r_mix  <= mix_sum;
                r_chst <= {ne.state, r_states};
            end else begin
                r_states[r_slot] <= ne.state;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mix_level      = r_mix;
    assign o_channel_states = r_chst;

    // A new request always starts at channel 0.
    a_start_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && (r_slot == 2'd0)))
        else $error("request did not start at channel 0");

    // Slots past channel 0 exist only within a request.
    a_slot_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot != 2'd0) |-> r_busy)
        else $error("slot advanced while idle");

    // Finishing the noise step loads a result.
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_slot == psgtn_pkg::CH_NOISE)) |=> r_out_valid)
        else $error("finished request lost its result");

    // The mix never exceeds full scale.
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_mix <= psgtn_pkg::MIX_FULL))
        else $error("mix level out of range");

endmodule

[dv/tb_psg_tone_noise_generator.sv]
// Self-checking testbench for psg_tone_noise_generator: directed table, then random
// write/tick requests under three idle patterns, checked against an in-bench predictor.
// Depends on psgtn_pkg and the generator RTL.
`timescale 1ns / 100ps

module tb_psg_tone_noise_generator;

    // Register select codes carried in bits 6-4 of a latch byte.
    localparam logic [2:0] SEL_ATT0      = 3'd1;
    localparam logic [2:0] SEL_TONE1     = 3'd2;
    localparam logic [2:0] SEL_ATT1      = 3'd3;
    localparam logic [2:0] SEL_TONE2     = 3'd4;
    localparam logic [2:0] SEL_ATT2      = 3'd5;
    localparam logic [2:0] SEL_NOISE_CTL = 3'd6;
    localparam logic [2:0] SEL_NOISE_ATT = 3'd7;

    localparam int RANDOM_PER_PHASE = 650;
    localparam int DRAIN_CYCLES     = 20;

    // Attenuation steps, full scale 1024; the last step mutes the channel.
    localparam int unsigned STEP_LEVEL [16] = '{
        1024, 813, 646, 513, 408, 324, 257, 204,
        162, 129, 102, 81, 65, 51, 41, 0
    };

    typedef struct packed {
        logic [12:0] mix;
        logic [3:0]  states;
    } t_mix_result;

    typedef struct {
        logic        req;
        logic [7:0]  wr_byte;
        bit          known;
        t_mix_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [0:0]  i_req_type;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [12:0] o_mix_level;
    logic [3:0]  o_channel_states;

    psg_tone_noise_generator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mix_level      (o_mix_level),
        .o_channel_states (o_channel_states)
    );

    // Predicted chip state, kept in step with every accepted request.
    logic [2:0]  m_select;
    logic [9:0]  m_tone [3];
    logic [2:0]  m_noise_ctl;
    logic [3:0]  m_atten [4];
    logic [10:0] m_reload [4];
    logic [10:0] m_count [4];
    logic        m_out [4];
    logic        m_div_toggle;
    logic [14:0] m_lfsr;

    t_mix_result mix_due [$];
    t_stim_row   directed_rows [$];

    int          tx_idle_pct = 7;
    int          rx_idle_pct = 50;
    int unsigned error_count = 0;
    int unsigned requests_sent = 0;
    int unsigned writes_sent = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned noise_shifts = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] latch_cmd(input logic [2:0] sel, input logic [3:0] val);
        return {1'b1, sel, val};
    endfunction

    function automatic logic [7:0] data_cmd(input logic [6:0] val);
        return {1'b0, val};
    endfunction

    function automatic void psg_reset_state();
        m_select     = 3'd0;
        m_noise_ctl  = 3'd0;
        m_div_toggle = 1'b0;
        m_lfsr       = psgtn_pkg::LFSR_SEED;
        for (int c = 0; c < 3; c++) m_tone[c] = 10'd0;
        for (int c = 0; c < 4; c++) begin
            m_atten[c] = psgtn_pkg::ATTEN_RESET;
            m_out[c]   = 1'b0;
        end
        m_reload[0] = 11'd1;
        m_reload[1] = 11'd1024;
        m_reload[2] = 11'd1024;
        m_reload[3] = psgtn_pkg::PERIOD_DIV16;
        for (int c = 0; c < 4; c++) m_count[c] = m_reload[c];
    endfunction

    // Apply one written byte: a latch byte latches a select, then update the selected register.
    function automatic void psg_write(input logic [7:0] d);
        logic [1:0] ch;
        logic [9:0] v;
        if (d[7]) m_select = d[6:4];
        ch = m_select[2:1];
        if (m_select[0]) begin
            m_atten[ch] = d[3:0];
        end else if (ch != psgtn_pkg::CH_NOISE) begin
            v = m_tone[ch];
            if (d[7]) v = {v[9:4], d[3:0]};
            else v = {d[5:0], v[3:0]};
            m_tone[ch]   = v;
            m_reload[ch] = (v == 10'd0) ? psgtn_pkg::PERIOD_ZERO : {1'b0, v};
        end else begin
            // Any noise write restarts the shift register; rate three keeps the old period.
            if (d[7]) m_noise_ctl = d[2:0];
            case (m_noise_ctl[1:0])
                psgtn_pkg::RATE_DIV16:
                    m_reload[psgtn_pkg::CH_NOISE] = psgtn_pkg::PERIOD_DIV16;
                psgtn_pkg::RATE_DIV32:
                    m_reload[psgtn_pkg::CH_NOISE] = psgtn_pkg::PERIOD_DIV32;
                psgtn_pkg::RATE_DIV64:
                    m_reload[psgtn_pkg::CH_NOISE] = psgtn_pkg::PERIOD_DIV64;
                default: ;
            endcase
            m_lfsr = psgtn_pkg::LFSR_SEED;
        end
    endfunction

    // Advance every channel by one reference tick.
    function automatic void psg_tick();
        logic from_tone2;
        logic shift_now;
        logic fb;
        from_tone2 = (m_noise_ctl[1:0] == psgtn_pkg::RATE_TONE2);
        shift_now  = 1'b0;
        for (int c = 0; c < 3; c++) begin
            m_count[c] = m_count[c] - 11'd1;
            if (m_count[c] == 11'd0) begin
                m_out[c]   = ~m_out[c];
                m_count[c] = m_reload[c];
                if (c == psgtn_pkg::CH_TONE2 && from_tone2) shift_now = m_out[c];
            end
        end
        if (!from_tone2) begin
            m_count[psgtn_pkg::CH_NOISE] = m_count[psgtn_pkg::CH_NOISE] - 11'd1;
            if (m_count[psgtn_pkg::CH_NOISE] == 11'd0) begin
                m_div_toggle                 = ~m_div_toggle;
                m_count[psgtn_pkg::CH_NOISE] = m_reload[psgtn_pkg::CH_NOISE];
                shift_now                    = m_div_toggle;
            end
        end
        if (shift_now) begin
            // White noise taps bits 0 and 1; periodic noise recirculates bit 0.
            fb = m_noise_ctl[2] ? (m_lfsr[0] ^ m_lfsr[1]) : m_lfsr[0];
            m_lfsr                    = {fb, m_lfsr[14:1]};
            m_out[psgtn_pkg::CH_NOISE] = m_lfsr[0];
            noise_shifts++;
        end
    endfunction

    // Work out the mix and channel states after one request.
    function automatic t_mix_result psg_step(input logic req, input logic [7:0] d);
        t_mix_result r;
        if (req == psgtn_pkg::REQ_WRITE) psg_write(d);
        else psg_tick();
        r.mix    = 13'd0;
        r.states = 4'd0;
        for (int c = 0; c < 4; c++) begin
            if (m_out[c]) begin
                r.mix       = r.mix + 13'(STEP_LEVEL[m_atten[c]]);
                r.states[c] = 1'b1;
            end
        end
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record its expected result.
    // A typed-in expectation, when given, replaces the predicted one.
    task automatic send_request(input logic req, input logic [7:0] d,
                                input bit known = 1'b0,
                                input t_mix_result want = '0);
        t_mix_result predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= d;
        do @(posedge i_clk); while (o_stall);
        predicted = psg_step(req, d);
        mix_due.push_back(known ? want : predicted);
        requests_sent++;
        if (req == psgtn_pkg::REQ_WRITE) writes_sent++;
        else ticks_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (mix_due.size() != 0) @(negedge i_clk);
    endtask

    // Random traffic, weighted toward short tone periods so the channels toggle
    // often and the noise shift register gets clocked from both sources.
    task automatic drive_random(input int unsigned count);
        int unsigned stop_at;
        int          roll;
        logic [5:0]  upper;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                send_request(psgtn_pkg::REQ_TICK, 8'($urandom));
            end else if (roll < 78) begin
                send_request(psgtn_pkg::REQ_WRITE,
                             latch_cmd({2'($urandom_range(0, 2)), 1'b0}, 4'($urandom)));
                if ($urandom_range(0, 3) != 0) begin
                    upper = ($urandom_range(0, 7) == 0) ? 6'($urandom)
                                                        : 6'($urandom_range(0, 1));
                    send_request(psgtn_pkg::REQ_WRITE, data_cmd({1'($urandom), upper}));
                end
            end else if (roll < 88) begin
                send_request(psgtn_pkg::REQ_WRITE,
                             latch_cmd({2'($urandom), 1'b1}, 4'($urandom)));
            end else if (roll < 94) begin
                send_request(psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_CTL, 4'($urandom)));
            end else begin
                send_request(psgtn_pkg::REQ_WRITE, 8'($urandom));
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_mix_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mix_due.size() == 0) begin
                $error("unexpected result: mix_level=%0d channel_states=%b",
                       o_mix_level, o_channel_states);
                error_count++;
            end else begin
                want = mix_due.pop_front();
                results_seen++;
                if (o_mix_level !== want.mix) begin
                    $error("mix_level: expected %0d, got %0d", want.mix, o_mix_level);
                    error_count++;
                end
                if (o_channel_states !== want.states) begin
                    $error("channel_states: expected %b, got %b",
                           want.states, o_channel_states);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_psg_tone_noise_generator: done, errors");
        $finish;
    end

    initial begin
        t_stim_row row;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = psgtn_pkg::REQ_WRITE;
        i_data_byte = 8'd0;
        psg_reset_state();

        // Directed table. Expectations are typed in for the first rows only,
        // where the state right after reset makes them obvious.
        directed_rows = '{
            // zero data byte to tone 0: period becomes 1024, nothing sounds yet
            '{psgtn_pkg::REQ_WRITE, data_cmd(7'h00), 1'b1, '{13'd0, 4'b0000}},
            // first tick: tone 0 counter expires at once, level of step four
            '{psgtn_pkg::REQ_TICK, 8'h00, 1'b1, '{13'd408, 4'b0001}},
            // loudest, muted, then second step on tone 0
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_ATT0, 4'h0), 1'b1, '{13'd1024, 4'b0001}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_ATT0, 4'hF), 1'b1, '{13'd0, 4'b0001}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_ATT0, 4'h1), 1'b1, '{13'd813, 4'b0001}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_ATT, 4'hF), 1'b0, '{13'd0, 4'b0}},
            // white noise clocked from tone 2, then a data write to the noise register
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_CTL, 4'h7), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, data_cmd(7'h3F), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_TONE2, 4'h0), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, data_cmd(7'h01), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_TICK, 8'h00, 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_TICK, 8'h80, 1'b0, '{13'd0, 4'b0}},
            // largest tone value, data bit 6 ignored
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_TONE2, 4'hF), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, data_cmd(7'h7F), 1'b0, '{13'd0, 4'b0}},
            // zero tone value on tone 1
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_TONE1, 4'h0), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, data_cmd(7'h00), 1'b0, '{13'd0, 4'b0}},
            // every noise rate, white and periodic
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_CTL, 4'h4), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_CTL, 4'h5), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_CTL, 4'h6), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_CTL, 4'h3), 1'b0, '{13'd0, 4'b0}},
            // tick carrying a full byte that must be ignored
            '{psgtn_pkg::REQ_TICK, 8'hFF, 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_ATT1, 4'h0), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_ATT2, 4'h0), 1'b0, '{13'd0, 4'b0}},
            '{psgtn_pkg::REQ_WRITE, latch_cmd(SEL_NOISE_ATT, 4'h0), 1'b0, '{13'd0, 4'b0}},
            // data byte into an attenuation register
            '{psgtn_pkg::REQ_WRITE, data_cmd(7'h7F), 1'b0, '{13'd0, 4'b0}}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_request(row.req, row.wr_byte, row.known, row.want);
        end

        // Phase one: sender rarely idles, receiver stalls half the time.
        drive_random(RANDOM_PER_PHASE);
        drain_results();

        // Phase two: the reverse.
        tx_idle_pct = 50;
        rx_idle_pct = 7;
        drive_random(RANDOM_PER_PHASE);
        drain_results();

        // Phase three: full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drive_random(RANDOM_PER_PHASE);
        drain_results();

        // Let any stray result surface before closing.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d writes and %0d ticks, %0d results checked",
                 writes_sent, ticks_sent, results_seen);
        $display("noise shift register clocked %0d times over three idle patterns",
                 noise_shifts);
        if (error_count == 0) begin
            $display("tb_psg_tone_noise_generator: done, clean");
        end else begin
            $display("tb_psg_tone_noise_generator: done, errors");
        end
        $finish;
    end

endmodule
